// File: hdl/shift_fifo_with_search_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the shift FIFO with search
// Property shorthands used by the top-level queue to check its own logic.
// ---------------------------------------------------------------------------
`ifndef SHIFT_FIFO_WITH_SEARCH_ASSERT_SVH
`define SHIFT_FIFO_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define SFS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define SFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sfs_pkg.sv
// ---------------------------------------------------------------------------
// Shift FIFO with search: shared definitions
// Sizes, command and status codes, beat types and the cell control bundle.
// ---------------------------------------------------------------------------
package sfs_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths of the response beat
  localparam int COUNT_W = 5;
  localparam int POS_W   = 4;

  localparam logic [2:0] FN_ENQ   = 3'd0;
  localparam logic [2:0] FN_DEQ   = 3'd1;
  localparam logic [2:0] FN_OVW   = 3'd2;
  localparam logic [2:0] FN_FIND  = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]                func;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] head_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic                      is_full;
    logic                      found;
    logic [POS_W-1:0]          position;
  } rsp_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic               load_tail;
    logic               load_head;
    logic               shift;
    logic               search;
    logic [CNT_W-1:0]   held;
    logic [VALUE_W-1:0] key;
  } sfs_ctl_t;

endpackage

// File: hdl/sfs_cell.sv
// ---------------------------------------------------------------------------
// Shift FIFO cell
// One slot of the queue: loads, shifts from its tail-side neighbour, compares.
// ---------------------------------------------------------------------------
module sfs_cell (
  input  logic                        clk,
  input  sfs_pkg::sfs_ctl_t           ctl,
  input  logic [sfs_pkg::IDX_W-1:0]   idx,
  input  logic [sfs_pkg::VALUE_W-1:0] neighbour,
  output logic [sfs_pkg::VALUE_W-1:0] data,
  output logic                        match
);

  logic live;

  // Only slots below the fill level take part in a search
  assign live = ({1'b0, idx} < (sfs_pkg::IDX_W + 1)'(ctl.held));

  always_ff @(posedge clk) begin
    if (ctl.load_tail && (sfs_pkg::CNT_W'(idx) == ctl.held)) begin
      data <= ctl.key;
    end else if (ctl.load_head && (idx == '0)) begin
      data <= ctl.key;
    end else if (ctl.shift) begin
      data <= neighbour;
    end
    if (ctl.search) begin
      match <= live && (data == ctl.key);
    end
  end

endmodule

// File: hdl/sfs_search.sv
// ---------------------------------------------------------------------------
// Shift FIFO match encoder
// Pick the lowest registered match flag and encode its position.
// ---------------------------------------------------------------------------
module sfs_search (
  input  logic [sfs_pkg::DEPTH-1:0] match,
  output logic                      found,
  output logic [sfs_pkg::IDX_W-1:0] pos
);

  logic [sfs_pkg::DEPTH-1:0] lowest;

  // Isolate the lowest set bit
  assign lowest = match & (~match + sfs_pkg::DEPTH'(1));
  assign found  = |match;

  always_comb begin
    pos = '0;
    for (int i = 0; i < sfs_pkg::DEPTH; i++) begin
      if (lowest[i]) begin
        pos = pos | sfs_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// File: hdl/shift_fifo_with_search.sv
// ---------------------------------------------------------------------------
// Shift FIFO with search
// Fixed-depth queue built as a row of slot cells, head always in cell 0.
// ---------------------------------------------------------------------------
// A command beat (enqueue, dequeue, overwrite head, search, clear) is taken
// when cmd_valid is high and cmd_stall low; each command gives exactly one
// response beat with status, dequeued value, new head, count, empty/full
// flags and the search result. One command is in flight at a time: in the
// cycle a beat is accepted every cell updates (load at the tail, shift one
// place towards the head, or overwrite the head) and, on a search, every cell
// registers its own key compare; the registered compares feed the match
// encoder, and the response is loaded into the output register once that
// register is free (rsp_valid low or rsp_stall low), so a stall can delay it.
// The next command is taken while the previous response still waits on rsp_stall.
// Dequeue or overwrite on an empty queue is rejected with the empty status,
// enqueue on a full queue with the full status; search looks only at held
// entries. Unused command codes change nothing and report the current state.
// ---------------------------------------------------------------------------
module shift_fifo_with_search (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sfs_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sfs_pkg::rsp_t rsp
);

`include "shift_fifo_with_search_assert.svh"

  logic                        accept;
  logic                        pend;
  logic                        pend_next;
  logic                        load_rsp;
  logic                        rsp_valid_next;
  logic [sfs_pkg::CNT_W-1:0]   held;
  logic [sfs_pkg::CNT_W-1:0]   held_next;
  logic                        empty_now;
  logic                        full_now;
  logic [1:0]                  status_next;
  logic [1:0]                  r_status;
  logic [sfs_pkg::VALUE_W-1:0] r_popped;
  logic                        r_search;
  sfs_pkg::sfs_ctl_t           ctl;
  logic [sfs_pkg::VALUE_W-1:0] cell_data [sfs_pkg::DEPTH];
  logic [sfs_pkg::VALUE_W-1:0] cell_nb   [sfs_pkg::DEPTH];
  logic [sfs_pkg::DEPTH-1:0]   match;
  logic                        any_match;
  logic [sfs_pkg::IDX_W-1:0]   match_pos;

  // Hold new commands while a response is still being formed, and in reset
  assign cmd_stall = pend || rst;
  assign accept    = cmd_valid && !cmd_stall;
  assign empty_now = (held == '0);
  assign full_now  = (held == sfs_pkg::CNT_W'(sfs_pkg::DEPTH));

  // Decode the command into cell controls, new fill level and status
  always_comb begin
    ctl           = '0;
    ctl.held      = held;
    ctl.key       = cmd.value;
    held_next     = held;
    status_next   = sfs_pkg::ST_OK;
    unique case (cmd.func)
      sfs_pkg::FN_ENQ: begin
        if (full_now) begin
          status_next = sfs_pkg::ST_FULL;
        end else begin
          ctl.load_tail = accept;
          held_next     = held + sfs_pkg::CNT_W'(1);
        end
      end
      sfs_pkg::FN_DEQ: begin
        if (empty_now) begin
          status_next = sfs_pkg::ST_EMPTY;
        end else begin
          ctl.shift = accept;
          held_next = held - sfs_pkg::CNT_W'(1);
        end
      end
      sfs_pkg::FN_OVW: begin
        if (empty_now) begin
          status_next = sfs_pkg::ST_EMPTY;
        end else begin
          ctl.load_head = accept;
        end
      end
      sfs_pkg::FN_FIND: begin
        ctl.search = accept;
        if (empty_now) begin
          status_next = sfs_pkg::ST_EMPTY;
        end
      end
      sfs_pkg::FN_CLEAR: begin
        held_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Row of slot cells; each takes its tail-side neighbour on a dequeue
  for (genvar i = 0; i < sfs_pkg::DEPTH; i++) begin : g_cell
    if (i == sfs_pkg::DEPTH - 1) begin : g_last
      assign cell_nb[i] = cell_data[i];
    end else begin : g_mid
      assign cell_nb[i] = cell_data[i+1];
    end
    sfs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (sfs_pkg::IDX_W'(i)),
      .neighbour (cell_nb[i]),
      .data      (cell_data[i]),
      .match     (match[i])
    );
  end

  sfs_search u_search (
    .match (match),
    .found (any_match),
    .pos   (match_pos)
  );

  // Load the pending response once the output register is free
  assign load_rsp       = pend && (!rsp_valid || !rsp_stall);
  assign pend_next      = accept ? 1'b1 : (load_rsp ? 1'b0 : pend);
  assign rsp_valid_next = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid : 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      held      <= '0;
    end else begin
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
      if (accept) begin
        held <= held_next;
      end
    end
  end

  // Payload of the command in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      r_status <= status_next;
      r_popped <= ctl.shift ? cell_data[0] : '0;
      r_search <= ctl.search && !empty_now;
    end
    if (load_rsp) begin
      rsp.status       <= r_status;
      rsp.popped_value <= r_popped;
      rsp.head_value   <= empty_now ? '0 : cell_data[0];
      rsp.count        <= sfs_pkg::COUNT_W'(held);
      rsp.is_empty     <= empty_now;
      rsp.is_full      <= full_now;
      rsp.found        <= r_search && any_match;
      rsp.position     <= (r_search && any_match) ? sfs_pkg::POS_W'(match_pos) : '0;
    end
  end

  // Fill level never passes the depth
  `SFS_ASSERT_IMP(a_held_bound, clk, rst, 1'b1, held <= sfs_pkg::CNT_W'(sfs_pkg::DEPTH), "fill level above depth")
  // An accepted beat always leaves a response pending
  `SFS_ASSERT_NEXT(a_accept_pend, clk, rst, accept, pend, "accepted command lost")
  // A hit only comes with the ok status
  `SFS_ASSERT_IMP(a_found_ok, clk, rst, rsp_valid && rsp.found, rsp.status == sfs_pkg::ST_OK, "hit reported on rejected search")

endmodule

// File: verif/shift_fifo_with_search_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Shift FIFO with search: self-checking testbench
// Drives command beats into the queue and checks every response beat against
// a shadow copy of the queue held here. A short table of directed commands
// covers the empty and full corners, duplicate keys and the unused codes.
// Random commands then follow, alternating between filling and draining
// phases, with random gaps on both channels and long response hold-offs.
// ---------------------------------------------------------------------------
module shift_fifo_with_search_tb;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_CHUNKS = 15;
  localparam int CHUNK_ITEMS   = 100;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_MAX    = 10;

  // Command codes that the block has no use for
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  typedef struct {
    sfs_pkg::cmd_t c;
    bit            typed;
    sfs_pkg::rsp_t r;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_stall;
  sfs_pkg::cmd_t cmd;
  logic          rsp_valid;
  logic          rsp_stall;
  sfs_pkg::rsp_t rsp;

  // Shadow copy of the queue, advanced on every accepted command beat
  logic [sfs_pkg::VALUE_W-1:0] shadow_slots [sfs_pkg::DEPTH];
  int                          shadow_held;

  sfs_pkg::rsp_t due_rsp_q [$];
  stim_row_t     dir_tab [$];

  int err_cnt;
  int mism_cnt;
  int beats_in;
  int beats_out;
  int hits;
  int full_rej;
  int empty_rej;
  int cycle_cnt;
  bit long_hold_req;

  shift_fifo_with_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Apply one command to the shadow queue and return the response it yields.
  function automatic sfs_pkg::rsp_t shadow_step(sfs_pkg::cmd_t c);
    sfs_pkg::rsp_t r;
    bit            hit;
    r   = '0;
    hit = 1'b0;
    r.status = sfs_pkg::ST_OK;
    case (c.func)
      sfs_pkg::FN_ENQ: begin
        if (shadow_held >= sfs_pkg::DEPTH) begin
          r.status = sfs_pkg::ST_FULL;
        end else begin
          shadow_slots[shadow_held] = c.value;
          shadow_held++;
        end
      end
      sfs_pkg::FN_DEQ: begin
        if (shadow_held == 0) begin
          r.status = sfs_pkg::ST_EMPTY;
        end else begin
          r.popped_value = shadow_slots[0];
          for (int i = 0; i < shadow_held - 1; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_held--;
        end
      end
      sfs_pkg::FN_OVW: begin
        if (shadow_held == 0) r.status = sfs_pkg::ST_EMPTY;
        else shadow_slots[0] = c.value;
      end
      sfs_pkg::FN_FIND: begin
        if (shadow_held == 0) begin
          r.status = sfs_pkg::ST_EMPTY;
        end else begin
          // only held entries count; the lowest match wins
          for (int i = 0; i < shadow_held; i++) begin
            if (!hit && shadow_slots[i] == c.value) begin
              hit        = 1'b1;
              r.found    = 1'b1;
              r.position = sfs_pkg::POS_W'(i);
            end
          end
        end
      end
      sfs_pkg::FN_CLEAR: shadow_held = 0;
      default: ;
    endcase
    r.head_value = (shadow_held != 0) ? shadow_slots[0] : '0;
    r.count      = sfs_pkg::COUNT_W'(shadow_held);
    r.is_empty   = (shadow_held == 0);
    r.is_full    = (shadow_held == sfs_pkg::DEPTH);
    return r;
  endfunction

  function automatic sfs_pkg::rsp_t empty_rsp(logic [1:0] st);
    sfs_pkg::rsp_t r;
    r          = '0;
    r.status   = st;
    r.is_empty = 1'b1;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(11, 40);
  endfunction

  // Small values give duplicate keys, so the lowest-match rule gets exercised
  function automatic logic [sfs_pkg::VALUE_W-1:0] random_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return sfs_pkg::VALUE_W'($urandom_range(0, 7));
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Fill phases lean on enqueue to reach full; drain phases lean on dequeue.
  // Search keys are mostly taken from entries held in the shadow queue.
  function automatic sfs_pkg::cmd_t random_cmd(bit fill_phase);
    sfs_pkg::cmd_t c;
    int            r;
    int            enq_lim;
    int            deq_lim;
    int            ovw_lim;
    int            find_lim;
    int            clr_lim;
    enq_lim  = fill_phase ? 450 : 200;
    deq_lim  = fill_phase ? 650 : 500;
    ovw_lim  = fill_phase ? 720 : 570;
    find_lim = fill_phase ? 960 : 900;
    clr_lim  = fill_phase ? 965 : 920;
    r        = $urandom_range(0, 999);
    c.value  = random_value();
    if (r < enq_lim) begin
      c.func = sfs_pkg::FN_ENQ;
    end else if (r < deq_lim) begin
      c.func = sfs_pkg::FN_DEQ;
    end else if (r < ovw_lim) begin
      c.func = sfs_pkg::FN_OVW;
    end else if (r < find_lim) begin
      c.func = sfs_pkg::FN_FIND;
      if (shadow_held > 0 && $urandom_range(0, 9) < 7)
        c.value = shadow_slots[$urandom_range(0, shadow_held - 1)];
    end else if (r < clr_lim) begin
      c.func = sfs_pkg::FN_CLEAR;
    end else begin
      c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    end
    return c;
  endfunction

  task automatic add_row(logic [2:0] f, logic [sfs_pkg::VALUE_W-1:0] v, bit typed,
                         sfs_pkg::rsp_t r);
    stim_row_t row;
    row.c.func  = f;
    row.c.value = v;
    row.typed   = typed;
    row.r       = r;
    dir_tab.push_back(row);
  endtask

  // Offer one command beat from the falling edge and hold it until taken.
  // The response is predicted at the edge that accepts it.
  task automatic send_cmd(sfs_pkg::cmd_t c, bit typed, sfs_pkg::rsp_t typed_rsp);
    sfs_pkg::rsp_t pred;
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    pred = shadow_step(c);
    due_rsp_q.push_back(typed ? typed_rsp : pred);
    beats_in++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted response has come back
  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Response side: random stall runs, calm stretches with no stall at all,
  // and a long hold-off whenever the command side asks for one.
  initial begin
    int run_left;
    int calm_left;
    int hold_left;
    bit calm;
    rsp_stall = 1'b0;
    run_left  = 0;
    calm_left = 0;
    hold_left = 0;
    calm      = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end
      calm_left--;
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < 35);
        run_left  = gap_len() - 1;
      end
    end
  end

  // Compare every accepted response beat with the oldest prediction
  always @(posedge clk) begin
    sfs_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_out++;
      if (rsp.found) hits++;
      if (rsp.status == sfs_pkg::ST_FULL) full_rej++;
      if (rsp.status == sfs_pkg::ST_EMPTY) empty_rej++;
      if (due_rsp_q.size() == 0) begin
        err_cnt++;
        mism_cnt++;
        if (mism_cnt <= REPORT_MAX)
          $display("unexpected response beat at cycle %0d", cycle_cnt);
      end else begin
        want = due_rsp_q.pop_front();
        if (want.status !== rsp.status || want.popped_value !== rsp.popped_value ||
            want.head_value !== rsp.head_value || want.count !== rsp.count ||
            want.is_empty !== rsp.is_empty || want.is_full !== rsp.is_full ||
            want.found !== rsp.found || want.position !== rsp.position) begin
          err_cnt++;
          mism_cnt++;
          if (mism_cnt <= REPORT_MAX) begin
            $display("mismatch on response beat %0d at cycle %0d", beats_out, cycle_cnt);
            $display("  exp: st=%0d pop=%h head=%h cnt=%0d empty=%b full=%b found=%b pos=%0d",
                     want.status, want.popped_value, want.head_value, want.count,
                     want.is_empty, want.is_full, want.found, want.position);
            $display("  got: st=%0d pop=%h head=%h cnt=%0d empty=%b full=%b found=%b pos=%0d",
                     rsp.status, rsp.popped_value, rsp.head_value, rsp.count,
                     rsp.is_empty, rsp.is_full, rsp.found, rsp.position);
          end
        end
      end
    end
  end

  // Watchdog: give up well beyond the slowest legal run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAIL");
    $finish;
  end

  initial begin
    sfs_pkg::rsp_t full_rsp;
    bit            fill_phase;
    bit            paced;
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    cmd           = '0;
    long_hold_req = 1'b0;
    shadow_held   = 0;
    err_cnt       = 0;
    mism_cnt      = 0;
    beats_in      = 0;
    beats_out     = 0;
    hits          = 0;
    full_rej      = 0;
    empty_rej     = 0;

    // Enqueue refused when full: the oldest entry still sits at the head
    full_rsp              = '0;
    full_rsp.status       = sfs_pkg::ST_FULL;
    full_rsp.head_value   = 32'sh8000_0000;
    full_rsp.count        = sfs_pkg::COUNT_W'(sfs_pkg::DEPTH);
    full_rsp.is_full      = 1'b1;

    // Each command but enqueue on an empty queue straight out of reset
    add_row(sfs_pkg::FN_DEQ,   32'h0123_4567, 1'b1, empty_rsp(sfs_pkg::ST_EMPTY));
    add_row(sfs_pkg::FN_OVW,   32'hdead_beef, 1'b1, empty_rsp(sfs_pkg::ST_EMPTY));
    add_row(sfs_pkg::FN_FIND,  32'h0000_0000, 1'b1, empty_rsp(sfs_pkg::ST_EMPTY));
    add_row(sfs_pkg::FN_CLEAR, 32'hffff_ffff, 1'b1, empty_rsp(sfs_pkg::ST_OK));
    add_row(FN_SPARE_LO,       32'h5555_5555, 1'b1, empty_rsp(sfs_pkg::ST_OK));
    // Fill to the brim: most negative first, most positive last, one duplicate
    for (int i = 0; i < sfs_pkg::DEPTH; i++) begin
      if (i == 0) add_row(sfs_pkg::FN_ENQ, 32'h8000_0000, 1'b0, '0);
      else if (i == sfs_pkg::DEPTH - 1) add_row(sfs_pkg::FN_ENQ, 32'h7fff_ffff, 1'b0, '0);
      else if (i == 9) add_row(sfs_pkg::FN_ENQ, 32'h4444_4444, 1'b0, '0);
      else add_row(sfs_pkg::FN_ENQ, 32'h1111_1111 * i, 1'b0, '0);
    end
    add_row(sfs_pkg::FN_ENQ,   32'haaaa_aaaa, 1'b1, full_rsp);
    add_row(sfs_pkg::FN_FIND,  32'h7fff_ffff, 1'b0, '0);
    add_row(sfs_pkg::FN_FIND,  32'h4444_4444, 1'b0, '0);
    add_row(sfs_pkg::FN_FIND,  32'h1234_5678, 1'b0, '0);
    add_row(sfs_pkg::FN_OVW,   32'hffff_ffff, 1'b0, '0);
    add_row(sfs_pkg::FN_DEQ,   32'h0000_0000, 1'b0, '0);
    add_row(FN_SPARE_HI,       32'h0f0f_0f0f, 1'b0, '0);
    add_row(FN_SPARE_MID,      32'h3c3c_3c3c, 1'b0, '0);
    add_row(sfs_pkg::FN_CLEAR, 32'h0000_0000, 1'b1, empty_rsp(sfs_pkg::ST_OK));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);
      if ($urandom_range(0, 1) == 0) pause(gap_len());
    end
    wait_drained();

    // Random part in chunks: odd and even chunks swap the fill bias, every
    // third chunk runs back to back, and two of those meet a long hold-off
    // so that the block backs up and stalls the command side.
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      fill_phase = (chunk % 2 == 0);
      paced      = (chunk % 3 != 0);
      if (chunk == 3 || chunk == 9) long_hold_req = 1'b1;
      if (chunk == 7) wait_drained();
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        send_cmd(random_cmd(fill_phase), 1'b0, '0);
        if (paced && $urandom_range(0, 1) == 0) pause(gap_len());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    err_cnt += due_rsp_q.size();

    $display("sent %0d commands, checked %0d responses in %0d cycles",
             beats_in, beats_out, cycle_cnt);
    $display("searches hit %0d, full refusals %0d, empty refusals %0d, mismatches %0d",
             hits, full_rej, empty_rej, mism_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
